>>> src/obbot_pkg.sv
// Shared widths, payload structs and axis codes for the oriented-box overlap test.
// Every other file imports this package.
package obbot_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int DIR_WIDTH   = 16;

   localparam int HALF_W  = COORD_WIDTH - 1;
   localparam int FRAC    = DIR_WIDTH - 1;
   localparam int DIFF_W  = COORD_WIDTH + 1;
   localparam int DPROD_W = 2 * DIR_WIDTH;
   localparam int DOT_W   = 2 * DIR_WIDTH + 1;
   localparam int MAG_W   = 2 * DIR_WIDTH;
   localparam int PPROD_W = DIFF_W + DIR_WIDTH;
   localparam int PSUM_W  = PPROD_W + 1;
   localparam int PMAG_W  = PPROD_W;
   localparam int EPROD_W = MAG_W + HALF_W;
   localparam int PSH_W   = PMAG_W + FRAC;
   localparam int RCH_W   = EPROD_W + 2;
   localparam int CMP_W   = (PSH_W > RCH_W) ? PSH_W : RCH_W;

   localparam int NUM_AXES    = 4;
   localparam int AXIS_W      = 3;
   localparam int AXIS_IDX_W  = $clog2(NUM_AXES);
   localparam int REQ_BITS    = 2 * (2 * COORD_WIDTH + 2 * DIR_WIDTH + 2 * HALF_W);
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = 1 + AXIS_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [AXIS_W-1:0] {
      AXIS_AX   = 3'd0,
      AXIS_AY   = 3'd1,
      AXIS_BX   = 3'd2,
      AXIS_BY   = 3'd3,
      AXIS_NONE = 3'd4
   } axis_type;

   // slot of each axis in the per-axis arrays
   localparam logic [AXIS_IDX_W-1:0] IDX_AX = 2'd0;
   localparam logic [AXIS_IDX_W-1:0] IDX_AY = 2'd1;
   localparam logic [AXIS_IDX_W-1:0] IDX_BX = 2'd2;
   localparam logic [AXIS_IDX_W-1:0] IDX_BY = 2'd3;

   // first member sits in the highest bits, so a_center_x lands at bit 0
   typedef struct packed {
      logic        [HALF_W-1:0]      b_half_y;
      logic        [HALF_W-1:0]      b_half_x;
      logic signed [DIR_WIDTH-1:0]   b_dir_y;
      logic signed [DIR_WIDTH-1:0]   b_dir_x;
      logic signed [COORD_WIDTH-1:0] b_center_y;
      logic signed [COORD_WIDTH-1:0] b_center_x;
      logic        [HALF_W-1:0]      a_half_y;
      logic        [HALF_W-1:0]      a_half_x;
      logic signed [DIR_WIDTH-1:0]   a_dir_y;
      logic signed [DIR_WIDTH-1:0]   a_dir_x;
      logic signed [COORD_WIDTH-1:0] a_center_y;
      logic signed [COORD_WIDTH-1:0] a_center_x;
   } req_type;

   typedef struct packed {
      logic [HALF_W-1:0] ahx;
      logic [HALF_W-1:0] ahy;
      logic [HALF_W-1:0] bhx;
      logic [HALF_W-1:0] bhy;
   } halves_type;

   // after stage 1: center difference and direction cross products
   typedef struct packed {
      logic signed [DIFF_W-1:0]    dx;
      logic signed [DIFF_W-1:0]    dy;
      logic signed [DIR_WIDTH-1:0] aux;
      logic signed [DIR_WIDTH-1:0] auy;
      logic signed [DIR_WIDTH-1:0] bux;
      logic signed [DIR_WIDTH-1:0] buy;
      logic signed [DPROD_W-1:0]   p_xx;
      logic signed [DPROD_W-1:0]   p_yy;
      logic signed [DPROD_W-1:0]   p_xy;
      logic signed [DPROD_W-1:0]   p_yx;
      halves_type                  h;
   } s1_type;

   // after stage 2: |cos|, |sin| of the relative angle and projection products
   typedef struct packed {
      logic        [MAG_W-1:0]   mag_c;
      logic        [MAG_W-1:0]   mag_s;
      logic signed [PPROD_W-1:0] pa_xx;
      logic signed [PPROD_W-1:0] pa_yy;
      logic signed [PPROD_W-1:0] pa_xy;
      logic signed [PPROD_W-1:0] pa_yx;
      logic signed [PPROD_W-1:0] pb_xx;
      logic signed [PPROD_W-1:0] pb_yy;
      logic signed [PPROD_W-1:0] pb_xy;
      logic signed [PPROD_W-1:0] pb_yx;
      halves_type                h;
   } s2_type;

   // after stage 3: per axis, projected distance and reach terms
   typedef struct packed {
      logic [NUM_AXES-1:0][PMAG_W-1:0]  proj;
      logic [NUM_AXES-1:0][EPROD_W-1:0] ext0;
      logic [NUM_AXES-1:0][EPROD_W-1:0] ext1;
      logic [NUM_AXES-1:0][HALF_W-1:0]  own;
   } s3_type;

   // after stage 4: both sides of each compare at one scale
   typedef struct packed {
      logic [NUM_AXES-1:0][CMP_W-1:0] proj;
      logic [NUM_AXES-1:0][CMP_W-1:0] reach;
   } s4_type;

endpackage

>>> src/obbot_prod.sv
// Stage 1: center differences and the four direction cross products.
// Depends on obbot_pkg.
module obbot_prod import obbot_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  logic    in_valid,
   input  req_type in_req,
   output logic    valid_ff,
   output s1_type  s1_ff
);

   s1_type s1_in;

   always_comb begin
      s1_in.dx   = DIFF_W'(in_req.a_center_x) - DIFF_W'(in_req.b_center_x);
      s1_in.dy   = DIFF_W'(in_req.a_center_y) - DIFF_W'(in_req.b_center_y);
      s1_in.aux  = in_req.a_dir_x;
      s1_in.auy  = in_req.a_dir_y;
      s1_in.bux  = in_req.b_dir_x;
      s1_in.buy  = in_req.b_dir_y;
      s1_in.p_xx = DPROD_W'(in_req.a_dir_x) * DPROD_W'(in_req.b_dir_x);
      s1_in.p_yy = DPROD_W'(in_req.a_dir_y) * DPROD_W'(in_req.b_dir_y);
      s1_in.p_xy = DPROD_W'(in_req.a_dir_x) * DPROD_W'(in_req.b_dir_y);
      s1_in.p_yx = DPROD_W'(in_req.a_dir_y) * DPROD_W'(in_req.b_dir_x);
      s1_in.h.ahx = in_req.a_half_x;
      s1_in.h.ahy = in_req.a_half_y;
      s1_in.h.bhx = in_req.b_half_x;
      s1_in.h.bhy = in_req.b_half_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
      end
   end

endmodule

>>> src/obbot_proj.sv
// Stage 2: magnitudes of the relative cos/sin terms and the eight
// center-difference projection products. Depends on obbot_pkg.
module obbot_proj import obbot_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   advance,
   input  logic   in_valid,
   input  s1_type in_s1,
   output logic   valid_ff,
   output s2_type s2_ff
);

   logic signed [DOT_W-1:0] dot_c;
   logic signed [DOT_W-1:0] dot_s;
   s2_type                  s2_in;

   always_comb begin
      // c = a.b, s = b x a; every cross-axis dot product is one of +-c, +-s
      dot_c = DOT_W'(in_s1.p_xx) + DOT_W'(in_s1.p_yy);
      dot_s = DOT_W'(in_s1.p_yx) - DOT_W'(in_s1.p_xy);
      s2_in.mag_c = dot_c[DOT_W-1] ? MAG_W'(-dot_c) : MAG_W'(dot_c);
      s2_in.mag_s = dot_s[DOT_W-1] ? MAG_W'(-dot_s) : MAG_W'(dot_s);
      s2_in.pa_xx = PPROD_W'(in_s1.dx) * PPROD_W'(in_s1.aux);
      s2_in.pa_yy = PPROD_W'(in_s1.dy) * PPROD_W'(in_s1.auy);
      s2_in.pa_xy = PPROD_W'(in_s1.dx) * PPROD_W'(in_s1.auy);
      s2_in.pa_yx = PPROD_W'(in_s1.dy) * PPROD_W'(in_s1.aux);
      s2_in.pb_xx = PPROD_W'(in_s1.dx) * PPROD_W'(in_s1.bux);
      s2_in.pb_yy = PPROD_W'(in_s1.dy) * PPROD_W'(in_s1.buy);
      s2_in.pb_xy = PPROD_W'(in_s1.dx) * PPROD_W'(in_s1.buy);
      s2_in.pb_yx = PPROD_W'(in_s1.dy) * PPROD_W'(in_s1.bux);
      s2_in.h     = in_s1.h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff <= s2_in;
      end
   end

endmodule

>>> src/obbot_reach.sv
// Stage 3: absolute projected distance on each axis and the other box's
// extent products. Depends on obbot_pkg.
module obbot_reach import obbot_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   advance,
   input  logic   in_valid,
   input  s2_type in_s2,
   output logic   valid_ff,
   output s3_type s3_ff
);

   logic signed [NUM_AXES-1:0][PSUM_W-1:0] psum;
   s3_type                                 s3_in;

   always_comb begin
      psum[IDX_AX] = PSUM_W'(in_s2.pa_xx) + PSUM_W'(in_s2.pa_yy);
      psum[IDX_AY] = PSUM_W'(in_s2.pa_yx) - PSUM_W'(in_s2.pa_xy);
      psum[IDX_BX] = PSUM_W'(in_s2.pb_xx) + PSUM_W'(in_s2.pb_yy);
      psum[IDX_BY] = PSUM_W'(in_s2.pb_yx) - PSUM_W'(in_s2.pb_xy);
      for (int i = 0; i < NUM_AXES; i++) begin
         s3_in.proj[i] = psum[i][PSUM_W-1] ? PMAG_W'(-$signed(psum[i]))
                                           : PMAG_W'(psum[i]);
      end
      // x axes see |c| on the other x extent, y axes see |s| there
      s3_in.ext0[IDX_AX] = EPROD_W'(in_s2.mag_c) * EPROD_W'(in_s2.h.bhx);
      s3_in.ext1[IDX_AX] = EPROD_W'(in_s2.mag_s) * EPROD_W'(in_s2.h.bhy);
      s3_in.ext0[IDX_AY] = EPROD_W'(in_s2.mag_s) * EPROD_W'(in_s2.h.bhx);
      s3_in.ext1[IDX_AY] = EPROD_W'(in_s2.mag_c) * EPROD_W'(in_s2.h.bhy);
      s3_in.ext0[IDX_BX] = EPROD_W'(in_s2.mag_c) * EPROD_W'(in_s2.h.ahx);
      s3_in.ext1[IDX_BX] = EPROD_W'(in_s2.mag_s) * EPROD_W'(in_s2.h.ahy);
      s3_in.ext0[IDX_BY] = EPROD_W'(in_s2.mag_s) * EPROD_W'(in_s2.h.ahx);
      s3_in.ext1[IDX_BY] = EPROD_W'(in_s2.mag_c) * EPROD_W'(in_s2.h.ahy);
      s3_in.own[IDX_AX]  = in_s2.h.ahx;
      s3_in.own[IDX_AY]  = in_s2.h.ahy;
      s3_in.own[IDX_BX]  = in_s2.h.bhx;
      s3_in.own[IDX_BY]  = in_s2.h.bhy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ff <= s3_in;
      end
   end

endmodule

>>> src/obbot_cmp.sv
// Stages 4 and 5: scale and sum the reach, then compare on all axes and
// pick the first separating one into the output register. Depends on obbot_pkg.
module obbot_cmp import obbot_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  s3_type   in_s3,
   output logic     valid_ff,
   output logic     overlap_ff,
   output axis_type axis_ff
);

   s4_type              s4_in;
   s4_type              s4_ff;
   logic                v4_ff;
   logic [NUM_AXES-1:0] sep;
   axis_type            axis_in;

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         s4_in.proj[i]  = CMP_W'(in_s3.proj[i]) << FRAC;
         s4_in.reach[i] = (CMP_W'(in_s3.own[i]) << (2 * FRAC))
                          + CMP_W'(in_s3.ext0[i]) + CMP_W'(in_s3.ext1[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sep[i] = s4_ff.proj[i] > s4_ff.reach[i];
      end
      // touching boxes do not separate
      if (sep[IDX_AX]) begin
         axis_in = AXIS_AX;
      end else if (sep[IDX_AY]) begin
         axis_in = AXIS_AY;
      end else if (sep[IDX_BX]) begin
         axis_in = AXIS_BX;
      end else if (sep[IDX_BY]) begin
         axis_in = AXIS_BY;
      end else begin
         axis_in = AXIS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff    <= 1'b0;
         valid_ff <= 1'b0;
      end else if (advance) begin
         v4_ff    <= in_valid;
         valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ff      <= s4_in;
         axis_ff    <= axis_in;
         overlap_ff <= (sep == '0);
      end
   end

endmodule

>>> src/obb_overlap_test_2d.sv
// Oriented rectangle overlap test by separating axes: each request carries two
// rectangles (Q16.16 centers and half extents, Q1.15 unit x directions, y axis
// taken as the perpendicular) and returns one response with the overlap flag
// and the first separating axis in the order a-x, a-y, b-x, b-y (4 = none).
// All products and sums are exact, so touching boxes report overlap. The block
// is a five-stage pipeline: it takes one request per clock whenever the response side
// is ready and returns one response for each accepted request. The
// whole pipeline advances together; a stall on the response side holds every
// stage in place, and the response register keeps its response until taken.
// Depends on obbot_pkg.
module obb_overlap_test_2d import obbot_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // fields, lowest bit up: a_center_x, a_center_y, a_dir_x, a_dir_y, a_half_x,
   // a_half_y, b_center_x, b_center_y, b_dir_x, b_dir_y, b_half_x, b_half_y, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // fields, lowest bit up: overlap, separating_axis, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic     advance;
   req_type  req;
   logic     v1_ff;
   s1_type   s1_ff;
   logic     v2_ff;
   s2_type   s2_ff;
   logic     v3_ff;
   s3_type   s3_ff;
   logic     overlap_ff;
   axis_type axis_ff;

   // advance everything while the response register is empty or being drained
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign req        = req_type'(req_tdata[REQ_BITS-1:0]);

   // stage 1: center differences, direction products
   obbot_prod u_prod (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .in_req   (req),
      .valid_ff (v1_ff),
      .s1_ff    (s1_ff)
   );

   // stage 2: |cos|, |sin| and projection products
   obbot_proj u_proj (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (v1_ff),
      .in_s1    (s1_ff),
      .valid_ff (v2_ff),
      .s2_ff    (s2_ff)
   );

   // stage 3: projected distances and extent products
   obbot_reach u_reach (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (v2_ff),
      .in_s2    (s2_ff),
      .valid_ff (v3_ff),
      .s3_ff    (s3_ff)
   );

   // stages 4 and 5: reach sum, compare, priority pick into the response register
   obbot_cmp u_cmp (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (v3_ff),
      .in_s3      (s3_ff),
      .valid_ff   (rsp_tvalid),
      .overlap_ff (overlap_ff),
      .axis_ff    (axis_ff)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_BITS){1'b0}}, axis_ff, overlap_ff};

endmodule

>>> tb/sv/obb_overlap_checker.sv
`timescale 1ns / 1ps
// Response checker for the oriented-box overlap test: watches both streams, predicts the
// first separating axis of every accepted request exactly and compares each response.
// Depends on obbot_pkg.
module obb_overlap_checker import obbot_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // fields, lowest bit up: a_center_x .. b_half_y as in req_type, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // fields, lowest bit up: overlap, separating_axis, zero pad
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     pending_axes,
   output int                     fail_count,
   output int                     responses_checked,
   output int                     overlaps_seen
);

   // wide enough that no product or sum of the test can wrap
   typedef logic signed [127:0] exact_t;

   axis_type       expected_axes[$];
   axis_type       want_axis;
   logic           got_overlap;
   logic [AXIS_W-1:0] got_axis;
   int             mismatches = 0;
   int             checked = 0;
   int             overlaps = 0;

   task automatic report_mismatch(input string what);
      $display("%0t mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Does axis u (owned by a box of half extent hs along it) split the boxes, given
   // the other box's x axis v and half extents hx, hy? Center term carries one
   // extra direction scale, own extent two, so all terms meet at one scale.
   function automatic bit axis_splits(input exact_t dx, dy, ux, uy, hs, vx, vy, hx, hy);
      exact_t proj, dot_x, dot_y, reach;
      proj = dx * ux + dy * uy;
      if (proj < 0)
         proj = -proj;
      proj = proj <<< FRAC;
      dot_x = vx * ux + vy * uy;
      dot_y = -vy * ux + vx * uy;
      if (dot_x < 0)
         dot_x = -dot_x;
      if (dot_y < 0)
         dot_y = -dot_y;
      reach = (hs <<< (2 * FRAC)) + dot_x * hx + dot_y * hy;
      // touching does not split
      return proj > reach;
   endfunction

   function automatic axis_type first_separating_axis(input req_type r);
      exact_t dx, dy, aux, auy, bux, buy, ahx, ahy, bhx, bhy;
      dx  = exact_t'($signed(r.a_center_x)) - exact_t'($signed(r.b_center_x));
      dy  = exact_t'($signed(r.a_center_y)) - exact_t'($signed(r.b_center_y));
      aux = exact_t'($signed(r.a_dir_x));
      auy = exact_t'($signed(r.a_dir_y));
      bux = exact_t'($signed(r.b_dir_x));
      buy = exact_t'($signed(r.b_dir_y));
      ahx = exact_t'(r.a_half_x);
      ahy = exact_t'(r.a_half_y);
      bhx = exact_t'(r.b_half_x);
      bhy = exact_t'(r.b_half_y);
      // y axes are the perpendicular (-uy, ux), formed exactly
      if (axis_splits(dx, dy, aux, auy, ahx, bux, buy, bhx, bhy))
         return AXIS_AX;
      if (axis_splits(dx, dy, -auy, aux, ahy, bux, buy, bhx, bhy))
         return AXIS_AY;
      if (axis_splits(dx, dy, bux, buy, bhx, aux, auy, ahx, ahy))
         return AXIS_BX;
      if (axis_splits(dx, dy, -buy, bux, bhy, aux, auy, ahx, ahy))
         return AXIS_BY;
      return AXIS_NONE;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_overlap = rsp_tdata[0];
            got_axis    = rsp_tdata[AXIS_W:1];
            if (expected_axes.size() == 0) begin
               report_mismatch($sformatf("response (overlap %b, axis %0d) with no request open",
                                         got_overlap, got_axis));
            end else begin
               want_axis = expected_axes.pop_front();
               if (got_overlap !== (want_axis == AXIS_NONE))
                  report_mismatch($sformatf("response %0d: overlap %b, expected %b",
                                            checked, got_overlap, want_axis == AXIS_NONE));
               if (got_axis !== want_axis)
                  report_mismatch($sformatf("response %0d: separating_axis %0d, expected %s",
                                            checked, got_axis, want_axis.name()));
               if (want_axis == AXIS_NONE)
                  overlaps++;
               checked++;
            end
         end
         if (req_tvalid && req_tready)
            expected_axes.push_back(first_separating_axis(req_type'(req_tdata[REQ_BITS-1:0])));
      end
      pending_axes      <= expected_axes.size();
      fail_count        <= mismatches;
      responses_checked <= checked;
      overlaps_seen     <= overlaps;
   end

endmodule

>>> tb/sv/obb_overlap_test_2d_tb.sv
`timescale 1ns / 1ps
// Top of the oriented-box overlap test bench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on obbot_pkg, obb_overlap_checker and the block.
module obb_overlap_test_2d_tb import obbot_pkg::*;;

   localparam int TOTAL_REQUESTS = 900;
   localparam int HOLD_CYCLES    = 200;
   localparam int HOLD_REQUESTS  = 48;
   // Q16.16 one, and cos 45 degrees in Q1.15
   localparam longint ONE  = 64'sh10000;
   localparam longint S45  = 23170;
   localparam longint DMAX = 32767;
   localparam longint DMIN = -32768;
   localparam longint CMAX = 64'sh7FFFFFFF;
   localparam longint CMIN = -64'sh80000000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int pending_axes;
   int fail_count;
   int responses_checked;
   int overlaps_seen;

   int requests_sent = 0;
   int drains = 0;
   bit hold_request = 1'b0;
   int holds_done = 0;

   obb_overlap_test_2d DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   obb_overlap_checker watch (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .pending_axes      (pending_axes),
      .fail_count        (fail_count),
      .responses_checked (responses_checked),
      .overlaps_seen     (overlaps_seen)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Build one request from plain numbers; each value is cut to its field width.
   function automatic req_type box_pair(input longint acx, acy, adx, ady, ahx, ahy,
                                        input longint bcx, bcy, bdx, bdy, bhx, bhy);
      req_type r;
      r.a_center_x = COORD_WIDTH'(acx);
      r.a_center_y = COORD_WIDTH'(acy);
      r.a_dir_x    = DIR_WIDTH'(adx);
      r.a_dir_y    = DIR_WIDTH'(ady);
      r.a_half_x   = HALF_W'(ahx);
      r.a_half_y   = HALF_W'(ahy);
      r.b_center_x = COORD_WIDTH'(bcx);
      r.b_center_y = COORD_WIDTH'(bcy);
      r.b_dir_x    = DIR_WIDTH'(bdx);
      r.b_dir_y    = DIR_WIDTH'(bdy);
      r.b_half_x   = HALF_W'(bhx);
      r.b_half_y   = HALF_W'(bhy);
      return r;
   endfunction

   // Mostly a unit vector at a random angle, sometimes raw bits; returns {y, x}.
   function automatic logic [2*DIR_WIDTH-1:0] random_direction();
      int c, s;
      if ($urandom_range(0, 6) == 0)
         return (2*DIR_WIDTH)'($urandom);
      c = $urandom_range(0, 32767);
      s = int'($sqrt(1073676289.0 - real'(c) * real'(c)));
      if ($urandom_range(0, 1) == 1)
         c = -c;
      if ($urandom_range(0, 1) == 1)
         s = -s;
      if ($urandom_range(0, 1) == 1)
         return {DIR_WIDTH'(c), DIR_WIDTH'(s)};
      return {DIR_WIDTH'(s), DIR_WIDTH'(c)};
   endfunction

   // Zero, all ones, largest signed, smallest signed or random, within bits.
   function automatic logic [31:0] corner_value(input int bits);
      logic [31:0] ones;
      ones = 32'hFFFF_FFFF >> (32 - bits);
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return ones;
         2: return ones >> 1;
         3: return 32'd1 << (bits - 1);
         default: return $urandom & ones;
      endcase
   endfunction

   function automatic req_type random_pair();
      req_type r;
      int kind, base_x, base_y, spread, half_top;
      kind = $urandom_range(0, 9);
      if (kind == 6 || kind == 7) begin
         // anything goes: every bit of every field
         r = req_type'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom, $urandom}));
      end else if (kind == 8) begin
         r.a_center_x = COORD_WIDTH'(corner_value(COORD_WIDTH));
         r.a_center_y = COORD_WIDTH'(corner_value(COORD_WIDTH));
         r.a_dir_x    = DIR_WIDTH'(corner_value(DIR_WIDTH));
         r.a_dir_y    = DIR_WIDTH'(corner_value(DIR_WIDTH));
         r.a_half_x   = HALF_W'(corner_value(HALF_W));
         r.a_half_y   = HALF_W'(corner_value(HALF_W));
         r.b_center_x = COORD_WIDTH'(corner_value(COORD_WIDTH));
         r.b_center_y = COORD_WIDTH'(corner_value(COORD_WIDTH));
         r.b_dir_x    = DIR_WIDTH'(corner_value(DIR_WIDTH));
         r.b_dir_y    = DIR_WIDTH'(corner_value(DIR_WIDTH));
         r.b_half_x   = HALF_W'(corner_value(HALF_W));
         r.b_half_y   = HALF_W'(corner_value(HALF_W));
      end else begin
         // boxes near each other, so overlap and every axis show up; kind 9 at large scale
         spread   = (kind == 9) ? (1 << 28) : (1 << 18);
         half_top = (kind == 9) ? (1 << 28) : (1 << 17);
         base_x   = (kind == 9) ? int'($urandom) : (int'($urandom) >>> 2);
         base_y   = (kind == 9) ? int'($urandom) : (int'($urandom) >>> 2);
         r.a_center_x = base_x;
         r.a_center_y = base_y;
         r.b_center_x = base_x + int'($urandom_range(0, 2 * spread)) - spread;
         r.b_center_y = base_y + int'($urandom_range(0, 2 * spread)) - spread;
         {r.a_dir_y, r.a_dir_x} = random_direction();
         {r.b_dir_y, r.b_dir_x} = random_direction();
         r.a_half_x = HALF_W'($urandom_range(0, half_top));
         r.a_half_y = HALF_W'($urandom_range(0, half_top));
         r.b_half_x = HALF_W'($urandom_range(0, half_top));
         r.b_half_y = HALF_W'($urandom_range(0, half_top));
      end
      return r;
   endfunction

   // Offer one request and hold it until the block takes it.
   task automatic offer(input req_type r);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - REQ_BITS){1'b0}}, r};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      requests_sent++;
   endtask

   task automatic idle(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop valid and wait until every expected response has been checked.
   task automatic drain_all();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_axes != 0)
         @(posedge clock);
      drains++;
   endtask

   // Response side: stall on a pattern that changes after each random span,
   // and on request take one long hold-off while the sender keeps pushing.
   initial begin
      int mode, span;
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 80);
         repeat (span) begin
            @(posedge clock);
            if (hold_request && holds_done == 0) begin
               rsp_tready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               holds_done++;
            end
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      req_type directed_pairs[$];
      int burst;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // coincident aligned squares, then clean splits on a-x and on a-y
      directed_pairs.push_back(box_pair(0, 0, DMAX, 0, ONE, ONE, 0, 0, DMAX, 0, ONE, ONE));
      directed_pairs.push_back(box_pair(0, 0, DMAX, 0, ONE, ONE,
                                        10 * ONE, 0, DMAX, 0, ONE, ONE));
      directed_pairs.push_back(box_pair(0, 0, DMAX, 0, ONE, ONE,
                                        0, 10 * ONE, DMAX, 0, ONE, ONE));
      // thin box b at 45 degrees, split only by its own x axis, then by its own y axis
      directed_pairs.push_back(box_pair(0, 0, DMAX, 0, ONE, ONE,
                                        3 * ONE / 2, 3 * ONE / 2, S45, S45, ONE / 10, 2 * ONE));
      directed_pairs.push_back(box_pair(0, 0, DMAX, 0, ONE, ONE,
                                        -3 * ONE / 2, 3 * ONE / 2, S45, S45, 2 * ONE, ONE / 10));
      // direction of exactly -1.0: boxes that touch overlap, one step further they split
      directed_pairs.push_back(box_pair(0, 0, DMIN, 0, ONE, ONE, 2 * ONE, 0, DMIN, 0, ONE, ONE));
      directed_pairs.push_back(box_pair(0, 0, DMIN, 0, ONE, ONE,
                                        2 * ONE + 1, 0, DMIN, 0, ONE, ONE));
      // x axis (0, -1.0): its perpendicular is +1.0, one bit wider than the field
      directed_pairs.push_back(box_pair(0, 0, 0, DMIN, ONE, ONE,
                                        2 * ONE + 1, 0, 0, DMIN, ONE, ONE));
      directed_pairs.push_back(box_pair(0, 0, 0, DMIN, ONE, ONE, 2 * ONE, 0, 0, DMIN, ONE, ONE));
      directed_pairs.push_back(box_pair(0, 0, 0, DMIN, ONE, ONE,
                                        0, -2 * ONE - 1, 0, DMIN, ONE, ONE));
      // non-unit directions used as they stand
      directed_pairs.push_back(box_pair(0, 0, DMIN, DMIN, ONE, 2 * ONE,
                                        5 * ONE, -ONE, DMIN, DMIN, ONE, ONE));
      directed_pairs.push_back(box_pair(ONE, -ONE, 100, -5, ONE, ONE,
                                        -3 * ONE, 2 * ONE, -7, 3, 3 * ONE, ONE / 2));
      directed_pairs.push_back(box_pair(0, 0, DMAX, DMIN, ONE, ONE,
                                        4 * ONE, 4 * ONE, DMIN, DMAX, ONE, ONE));
      // zero directions: those axes never split, even for far-apart boxes
      directed_pairs.push_back(box_pair(CMAX, CMAX, 0, 0, 0, 0, CMIN, CMIN, 0, 0, 0, 0));
      directed_pairs.push_back(box_pair(CMAX, 0, 0, 0, ONE, ONE, CMIN, 0, DMAX, 0, ONE, ONE));
      directed_pairs.push_back(box_pair(0, CMIN, DMIN, 0, ONE, ONE, 0, CMAX, 0, 0, ONE, ONE));
      // extremes of centers and half extents
      directed_pairs.push_back(box_pair(CMAX, CMAX, DMAX, 0, 0, 0, CMIN, CMIN, DMAX, 0, 0, 0));
      directed_pairs.push_back(box_pair(CMAX, CMAX, DMAX, 0, CMAX, CMAX,
                                        CMIN, CMIN, DMAX, 0, CMAX, CMAX));
      directed_pairs.push_back(box_pair(CMAX, CMAX, DMAX, DMAX, CMAX, CMAX,
                                        CMIN, CMIN, DMIN, DMIN, 0, 0));
      directed_pairs.push_back(box_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // zero-size boxes at one point touch
      directed_pairs.push_back(box_pair(ONE, ONE, S45, S45, 0, 0, ONE, ONE, DMIN, DMAX, 0, 0));
      foreach (directed_pairs[i])
         offer(directed_pairs[i]);
      drain_all();

      // long hold-off on the response side with requests streaming in
      hold_request = 1'b1;
      repeat (HOLD_REQUESTS) offer(random_pair());
      drain_all();

      // random bursts with random gaps, now and then a full drain
      while (requests_sent < TOTAL_REQUESTS) begin
         burst = $urandom_range(1, 16);
         repeat (burst) offer(random_pair());
         if ($urandom_range(0, 3) != 0)
            idle($urandom_range(1, 8));
         if ($urandom_range(0, 39) == 0)
            drain_all();
      end

      drain_all();
      repeat (10) @(posedge clock);
      $display("covered %0d box pairs (%0d directed), %0d responses checked, %0d overlapping",
               requests_sent, directed_pairs.size(), responses_checked, overlaps_seen);
      $display("response hold-offs of %0d cycles: %0d, full drains: %0d",
               HOLD_CYCLES, holds_done, drains);
      if (fail_count == 0)
         $display("[obb_overlap_test_2d] OK");
      else
         $display("[obb_overlap_test_2d] ERROR");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("timeout with %0d responses still expected", pending_axes);
      $display("[obb_overlap_test_2d] ERROR");
      $finish;
   end

endmodule
